// ----- design/hsfc_pkg.sv -----
// ============================================================================
// hsfc_pkg: shared constants for the half/single float converter
// Holds the mode codes and the special bit patterns used by the converter.
// ============================================================================
package hsfc_pkg;

    // Conversion direction codes.
    localparam logic MODE_NARROW = 1'b0;
    localparam logic MODE_WIDEN  = 1'b1;

    // Binary16 special patterns.
    localparam logic [14:0] HALF_QNAN    = 15'h7E00;
    localparam logic [14:0] HALF_INF     = 15'h7C00;
    localparam logic [14:0] HALF_MAX     = 15'h7BFF;

    // Binary32 exponent field of infinity and NaN.
    localparam logic [7:0]  SINGLE_EXP_MAX = 8'hFF;

endpackage

// ----- design/half_single_float_converter.sv -----
// ============================================================================
// half_single_float_converter: binary32 <-> binary16 conversion
// Narrows with round to nearest even and saturation (exponent fields below 103 flush to zero), or widens exactly.
// ============================================================================
// A start beat is captured in the operand register; its result is shown with the strobe from the result register.
// Throughput: one beat per cycle; busy is never asserted.
// The operand register and the result register set the latency.
// Reset clears the valid flags only; no result is shown after reset.
module half_single_float_converter
    import hsfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] value_bits,
    output logic        strobe,
    output logic [31:0] result_bits
);

    logic        in_valid_reg;
    logic        mode_reg;
    logic [31:0] value_reg;
    logic        out_valid_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    // Narrowing path signals.
    logic        n_sign;
    logic [7:0]  n_exp;
    logic [22:0] n_frac;
    logic [10:0] n_hm;
    logic        n_round;
    logic [10:0] n_hm_rnd;
    logic [4:0]  n_sh;
    logic [23:0] n_m;
    logic [23:0] n_mask;
    logic [23:0] n_rem;
    logic [23:0] n_half;
    logic [10:0] n_sub;
    logic        n_sub_rnd;
    logic [14:0] n_mag;

    // Widening path signals.
    logic [4:0]  w_exp;
    logic [9:0]  w_frac;
    logic [3:0]  w_lz;
    logic [9:0]  w_norm;
    logic [7:0]  w_e;
    logic [31:0] w_res;

    assign busy = 1'b0;

    // Operand register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg  <= mode;
            value_reg <= value_bits;
        end
    end

    // Narrowing: binary32 to binary16.
    always_comb
    begin
        n_sign   = value_reg[31];
        n_exp    = value_reg[30:23];
        n_frac   = value_reg[22:0];
        // Normal range rounding at bit 13.
        n_hm     = {1'b0, n_frac[22:13]};
        n_round  = n_frac[12] && ((n_frac[11:0] != 12'd0) || n_frac[13]);
        n_hm_rnd = n_hm + {10'd0, n_round};
        // Subnormal range: shift of 14..23 for exponent fields 103..112.
        n_sh     = 5'(8'd126 - n_exp);
        n_m      = {1'b1, n_frac};
        n_mask   = (24'd1 << n_sh) - 24'd1;
        n_rem    = n_m & n_mask;
        n_half   = 24'd1 << (n_sh - 5'd1);
        n_sub    = 11'(n_m >> n_sh);
        n_sub_rnd = (n_rem > n_half) || ((n_rem == n_half) && n_sub[0]);
        if (n_exp == SINGLE_EXP_MAX)
        begin
            n_mag = (n_frac != 23'd0) ? HALF_QNAN : HALF_INF;
        end
        else if (n_exp > 8'd142)
        begin
            n_mag = HALF_MAX;
        end
        else if (n_exp >= 8'd113)
        begin
            if (n_hm_rnd[10])
            begin
                if (n_exp == 8'd142)
                begin
                    n_mag = HALF_MAX;
                end
                else
                begin
                    n_mag = {5'(n_exp - 8'd111), 10'd0};
                end
            end
            else
            begin
                n_mag = {5'(n_exp - 8'd112), n_hm_rnd[9:0]};
            end
        end
        else if (n_exp >= 8'd103)
        begin
            n_mag = 15'(n_sub + {10'd0, n_sub_rnd});
        end
        else
        begin
            n_mag = 15'd0;
        end
    end

    // Widening: binary16 to binary32, with a leading-zero count.
    always_comb
    begin
        w_exp  = value_reg[14:10];
        w_frac = value_reg[9:0];
        w_lz   = 4'd10;
        for (int i = 0; i < 10; i++)
        begin
            if (w_frac[i])
            begin
                w_lz = 4'(9 - i);
            end
        end
        w_norm = 10'(w_frac << (w_lz + 4'd1));
        w_e    = 8'(8'd112 - {4'd0, w_lz});
        if (w_exp == 5'd0)
        begin
            if (w_frac == 10'd0)
            begin
                w_res = {value_reg[15], 31'd0};
            end
            else
            begin
                w_res = {value_reg[15], w_e, w_norm, 13'd0};
            end
        end
        else if (w_exp == 5'd31)
        begin
            w_res = {value_reg[15], SINGLE_EXP_MAX, w_frac, 13'd0};
        end
        else
        begin
            w_res = {value_reg[15], 8'({3'd0, w_exp} + 8'd112), w_frac, 13'd0};
        end
    end

    assign result_next = (mode_reg == MODE_WIDEN) ? w_res
                                                  : {16'd0, n_sign, n_mag};

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign strobe      = out_valid_reg;
    assign result_bits = result_reg;

endmodule

// ----- design/hsfc_checker.sv -----
// ============================================================================
// hsfc_checker: port-level checks for the converter
// Checks latency, busy and the narrowing result form as seen at the ports.
// ============================================================================
module hsfc_checker
    import hsfc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        mode,
    input logic [31:0] value_bits,
    input logic        strobe,
    input logic [31:0] result_bits
);

    // Every beat yields a result strobe.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 strobe)
        else $error("missing result strobe");

    // No strobe without an earlier beat.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start, 2))
        else $error("result strobe without beat");

    // Narrowing results keep the upper half zero.
    a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (start && mode == MODE_NARROW) |-> ##2 (result_bits[31:16] == 16'd0))
        else $error("narrow result upper half not zero");

    // Narrowing keeps the sign.
    a_narrow_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (start && mode == MODE_NARROW) |-> ##2 (result_bits[15] == $past(value_bits[31], 2)))
        else $error("narrow result sign mismatch");

    // The converter never stalls.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy asserted");

endmodule

bind half_single_float_converter hsfc_checker u_hsfc_checker (.*);
